// File: src/ens_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ens_pkg: shared constants for the eight-neighbor average stencil
// Default sizes, register field widths, register indexes, reset values and the smallest grid extent.
// ----------------------------------------------------------------------------
package ens_pkg;

	// default sizes handed to the top level parameters
	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 32;

	// register field widths
	localparam int GRID_WIDTH_W  = 11;
	localparam int GRID_HEIGHT_W = 16;
	localparam int ROW_W         = 16;

	// APB port geometry: two registers on a 32-bit data port at byte addresses 0 and 4
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = 1;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

	// register reset values
	localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
	localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = 16'd1024;

	// smallest usable grid extent
	localparam int MIN_EXTENT = 3;

endpackage : ens_pkg
`default_nettype wire

// File: src/eight_neighbor_average_stencil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eight_neighbor_average_stencil: 3x3 eight-neighbor mean over a raster grid
// Streams signed fixed-point samples in raster order and emits, for every
// interior point, the floored eighth of the sum of its eight neighbors.
// ----------------------------------------------------------------------------
// The block takes one sample per clock unless a stalled result channel backs
// up the pipeline, and keeps that rate for any frame size: each sample costs
// one read and one write of each of the two line store RAMs (one read port,
// one write port each) and nothing else. A result word passes the line store
// read, pair sums, sums of four, then the final add in the output register.
// Border points give no result, so a frame of
// H rows and W columns yields (H-2)*(W-2) result words, the last one flagged
// by frame_last. Any register write restarts the frame at row 0, column 0;
// the line stores are always refilled before they are read, so no clearing
// pass runs after reset. grid_width is clamped to 3..MAX_WIDTH and
// grid_height to at least 3.
// ----------------------------------------------------------------------------
module eight_neighbor_average_stencil #(
	parameter int MAX_WIDTH   = ens_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = ens_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// APB configuration port
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [ens_pkg::PADDR_W-1:0]          paddr,
	input  wire logic [ens_pkg::PDATA_W-1:0]          pwdata,
	output      logic [ens_pkg::PDATA_W-1:0]          prdata,
	output      logic                                 pready,
	// sample channel
	input  wire logic                                 sample_valid,
	output      logic                                 sample_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]        sample,
	// result channel
	output      logic                                 result_valid,
	input  wire logic                                 result_ready,
	output      logic signed [SAMPLE_BITS-1:0]        average,
	output      logic [ens_pkg::ROW_W-1:0]            out_row,
	output      logic [$clog2(MAX_WIDTH)-1:0]         out_col,
	output      logic                                 frame_last
);

	localparam int SB     = SAMPLE_BITS;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = ens_pkg::ROW_W;
	localparam int GW     = ens_pkg::GRID_WIDTH_W;
	localparam int GH     = ens_pkg::GRID_HEIGHT_W;
	localparam int WCMP_W = (COL_W + 1 > GW) ? COL_W + 1 : GW;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [GW-1:0]                    grid_width_q;
	logic [GH-1:0]                    grid_height_q;
	logic                             cfg_wr;
	logic [ens_pkg::REG_IDX_W-1:0]    reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ens_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	// write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= ens_pkg::GRID_WIDTH_RST;
			grid_height_q <= ens_pkg::GRID_HEIGHT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				ens_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[GW-1:0];
				ens_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[GH-1:0];
				default: ;
			endcase
		end
	end

	// read back the addressed register
	always_comb begin
		case (reg_idx)
			ens_pkg::REG_GRID_WIDTH:  prdata = ens_pkg::PDATA_W'(grid_width_q);
			ens_pkg::REG_GRID_HEIGHT: prdata = ens_pkg::PDATA_W'(grid_height_q);
			default:                  prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// clamped frame extents, as last column and last row indexes
	// ------------------------------------------------------------------
	logic [WCMP_W-1:0] width_ext;
	logic [COL_W-1:0]  last_col;
	logic [ROW_W-1:0]  last_row;

	assign width_ext = WCMP_W'(grid_width_q);

	always_comb begin
		if (width_ext < WCMP_W'(ens_pkg::MIN_EXTENT)) begin
			last_col = COL_W'(ens_pkg::MIN_EXTENT - 1);
		end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
			last_col = COL_W'(MAX_WIDTH - 1);
		end else begin
			last_col = COL_W'(width_ext - WCMP_W'(1));
		end
	end

	always_comb begin
		if (grid_height_q < GH'(ens_pkg::MIN_EXTENT)) begin
			last_row = ROW_W'(ens_pkg::MIN_EXTENT - 1);
		end else begin
			last_row = ROW_W'(grid_height_q - GH'(1));
		end
	end

	// ------------------------------------------------------------------
	// pipeline flow control: a stage advances when it is empty or the
	// stage after it advances
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, result_valid_q;
	logic adv_out, adv3, adv2, adv1;
	logic accept;

	assign adv_out      = !result_valid_q || result_ready;
	assign adv3         = !valid_s3 || adv_out;
	assign adv2         = !valid_s2 || adv3;
	assign adv1         = !valid_s1 || adv2;
	assign sample_ready = adv1;
	assign accept       = sample_valid && adv1;

	// ------------------------------------------------------------------
	// raster position counters
	// ------------------------------------------------------------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// advance per accepted word, restart the frame on any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == last_col) begin
				col_q <= '0;
				if (row_q == last_row) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// stage 1: line store read in flight
	// ------------------------------------------------------------------
	logic [SB-1:0]    sample_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			col_s1    <= col_q;
			row_s1    <= row_q;
		end
	end

	// ------------------------------------------------------------------
	// line stores: read column c on accept, write it back when stage 1 moves on.
	// The next read of the same column is at least three words away, so
	// read and write never meet on one entry.
	// ------------------------------------------------------------------
	logic [SB-1:0] up_rd, mid_rd;
	logic          fire1;

	assign fire1 = valid_s1 && adv2;

	ens_ram #(
		.WIDTH (SB),
		.DEPTH (MAX_WIDTH)
	) u_upper_line (
		.clk   (clk),
		.we    (fire1),
		.waddr (col_s1),
		.wdata (mid_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (up_rd)
	);

	ens_ram #(
		.WIDTH (SB),
		.DEPTH (MAX_WIDTH)
	) u_middle_line (
		.clk   (clk),
		.we    (fire1),
		.waddr (col_s1),
		.wdata (sample_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (mid_rd)
	);

	// ------------------------------------------------------------------
	// 3x3 window: [0..2] column c-2 (top, mid, bottom), [3..5] column c-1
	// ------------------------------------------------------------------
	logic [SB-1:0] win_q [6];

	// shift one column per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (fire1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up_rd;
			win_q[4] <= mid_rd;
			win_q[5] <= sample_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: pairwise sums of the eight neighbors, center left out
	// ------------------------------------------------------------------
	logic              interior_s1;
	logic              last_s1;
	logic [SB:0]       pair_s2 [4];
	logic [ROW_W-1:0]  row_s2;
	logic [COL_W-1:0]  col_s2;
	logic              last_s2;

	assign interior_s1 = (row_s1 >= ROW_W'(2)) && (col_s1 >= COL_W'(2));
	assign last_s1     = (row_s1 == last_row) && (col_s1 == last_col);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1 && interior_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			pair_s2[0] <= {win_q[0][SB-1], win_q[0]} + {win_q[3][SB-1], win_q[3]};
			pair_s2[1] <= {up_rd[SB-1], up_rd} + {win_q[1][SB-1], win_q[1]};
			pair_s2[2] <= {mid_rd[SB-1], mid_rd} + {win_q[2][SB-1], win_q[2]};
			pair_s2[3] <= {win_q[5][SB-1], win_q[5]} + {sample_s1[SB-1], sample_s1};
			row_s2     <= row_s1 - ROW_W'(1);
			col_s2     <= col_s1 - COL_W'(1);
			last_s2    <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: sums of four
	// ------------------------------------------------------------------
	logic [SB+1:0]    quad_s3 [2];
	logic [ROW_W-1:0] row_s3;
	logic [COL_W-1:0] col_s3;
	logic             last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && adv3) begin
			quad_s3[0] <= {pair_s2[0][SB], pair_s2[0]} + {pair_s2[1][SB], pair_s2[1]};
			quad_s3[1] <= {pair_s2[2][SB], pair_s2[2]} + {pair_s2[3][SB], pair_s2[3]};
			row_s3     <= row_s2;
			col_s3     <= col_s2;
			last_s3    <= last_s2;
		end
	end

	// ------------------------------------------------------------------
	// output register: final add, floor divide by eight as a bit drop
	// ------------------------------------------------------------------
	logic [SB+2:0]    total;
	logic [SB-1:0]    average_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             frame_last_q;

	assign total = {quad_s3[0][SB+1], quad_s3[0]} + {quad_s3[1][SB+1], quad_s3[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_out) begin
			result_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && adv_out) begin
			average_q    <= total[SB+2:3];
			out_row_q    <= row_s3;
			out_col_q    <= col_s3;
			frame_last_q <= last_s3;
		end
	end

	assign result_valid = result_valid_q;
	assign average      = average_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign frame_last   = frame_last_q;

endmodule : eight_neighbor_average_stencil
`default_nettype wire

// File: src/ens_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ens_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ens_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds its data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : ens_ram
`default_nettype wire

// File: test/eight_neighbor_average_stencil_tb.sv
// ----------------------------------------------------------------------------
// eight_neighbor_average_stencil_tb: self-checking bench for the 3x3 stencil
// Streams raster samples through the block under many grid sizes. It predicts
// every eight-neighbor average with its own line stores and window, and
// compares each result word field by field. Both channels idle and stall at
// random, and the register port is read back after every write.
// ----------------------------------------------------------------------------
module eight_neighbor_average_stencil_tb;

	localparam int SB    = ens_pkg::SAMPLE_BITS_DEF;
	localparam int MAXW  = ens_pkg::MAX_WIDTH_DEF;
	localparam int COL_W = $clog2(MAXW);
	localparam int ROW_W = ens_pkg::ROW_W;
	localparam int PDW   = ens_pkg::PDATA_W;
	localparam int IDXW  = ens_pkg::REG_IDX_W;
	localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

	typedef struct {
		logic signed [SB-1:0] average;
		logic [ROW_W-1:0]     row;
		logic [COL_W-1:0]     col;
		logic                 last;
	} stencil_point_t;

	// predicts interior-point averages and holds them until the block emits them
	class stencil_scoreboard_t;
		logic signed [SB-1:0] upper_store [MAXW];
		logic signed [SB-1:0] middle_store [MAXW];
		// [0..2] column c-2 top/mid/bottom, [3..5] column c-1
		logic signed [SB-1:0] window [6];
		int col_pos;
		int row_pos;
		logic [ens_pkg::GRID_WIDTH_W-1:0]  width_reg;
		logic [ens_pkg::GRID_HEIGHT_W-1:0] height_reg;
		stencil_point_t expected_points [$];
		int mismatches;
		int samples_seen;
		int points_checked;
		int frames_closed;

		function void reset_state();
			foreach (upper_store[i]) begin
				upper_store[i]  = '0;
				middle_store[i] = '0;
			end
			foreach (window[i])
				window[i] = '0;
			col_pos    = 0;
			row_pos    = 0;
			width_reg  = ens_pkg::GRID_WIDTH_RST;
			height_reg = ens_pkg::GRID_HEIGHT_RST;
		endfunction

		function int eff_width();
			if (width_reg < ens_pkg::MIN_EXTENT)
				return ens_pkg::MIN_EXTENT;
			if (width_reg > MAXW)
				return MAXW;
			return int'(width_reg);
		endfunction

		function int eff_height();
			return (height_reg < ens_pkg::MIN_EXTENT) ? ens_pkg::MIN_EXTENT
				: int'(height_reg);
		endfunction

		// any write restarts the frame
		function void write_reg(logic [IDXW-1:0] idx, logic [PDW-1:0] value);
			if (idx == ens_pkg::REG_GRID_WIDTH)
				width_reg = value[ens_pkg::GRID_WIDTH_W-1:0];
			else
				height_reg = value[ens_pkg::GRID_HEIGHT_W-1:0];
			col_pos = 0;
			row_pos = 0;
		endfunction

		function logic [PDW-1:0] reg_value(logic [IDXW-1:0] idx);
			return (idx == ens_pkg::REG_GRID_WIDTH) ? PDW'(width_reg) : PDW'(height_reg);
		endfunction

		function void flag(string msg);
			if (mismatches < 10)
				$display("mismatch: %s", msg);
			mismatches++;
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		// advance the window by one accepted sample word
		function void note_sample(logic signed [SB-1:0] s);
			int w;
			int h;
			int c;
			int r;
			logic signed [SB-1:0] up;
			logic signed [SB-1:0] mid;
			logic signed [SB+2:0] sum;
			stencil_point_t p;
			w = eff_width();
			h = eff_height();
			c = (col_pos >= w) ? 0 : col_pos;
			r = (row_pos >= h) ? 0 : row_pos;
			up  = upper_store[c];
			mid = middle_store[c];
			samples_seen++;

			// interior point (r-1, c-1): all neighbors except the center window[4]
			if (r >= 2 && c >= 2) begin
				sum = window[0] + window[3] + up + window[1] + mid
					+ window[2] + window[5] + s;
				p.average = SB'(sum >>> 3);
				p.row     = ROW_W'(r - 1);
				p.col     = COL_W'(c - 1);
				p.last    = (r == h - 1) && (c == w - 1);
				expected_points.push_back(p);
			end

			// shift window and line stores
			window[0] = window[3];
			window[1] = window[4];
			window[2] = window[5];
			window[3] = up;
			window[4] = mid;
			window[5] = s;
			upper_store[c]  = mid;
			middle_store[c] = s;

			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= h)
					r = 0;
			end
			col_pos = c;
			row_pos = r;
		endfunction

		function void check_result(logic signed [SB-1:0] a, logic [ROW_W-1:0] r,
				logic [COL_W-1:0] c, logic l);
			stencil_point_t p;
			if (expected_points.size() == 0) begin
				flag($sformatf("word at row %0d col %0d with nothing expected", r, c));
				return;
			end
			p = expected_points.pop_front();
			points_checked++;
			if (p.last)
				frames_closed++;
			if (a !== p.average)
				flag($sformatf("average at (%0d,%0d): expected %0d got %0d",
					p.row, p.col, p.average, a));
			if (r !== p.row)
				flag($sformatf("out_row: expected %0d got %0d", p.row, r));
			if (c !== p.col)
				flag($sformatf("out_col: expected %0d got %0d", p.col, c));
			if (l !== p.last)
				flag($sformatf("frame_last at (%0d,%0d): expected %0b got %0b",
					p.row, p.col, p.last, l));
		endfunction
	endclass

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           psel         = 1'b0;
	logic                           penable      = 1'b0;
	logic                           pwrite       = 1'b0;
	logic [ens_pkg::PADDR_W-1:0]    paddr        = '0;
	logic [PDW-1:0]                 pwdata       = '0;
	logic [PDW-1:0]                 prdata;
	logic                           pready;
	logic                           sample_valid = 1'b0;
	logic                           sample_ready;
	logic signed [SB-1:0]           sample       = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	logic signed [SB-1:0]           average;
	logic [ROW_W-1:0]               out_row;
	logic [COL_W-1:0]               out_col;
	logic                           frame_last;

	stencil_scoreboard_t sb;
	bit idle_on = 1'b1;
	int hold_request = 0;
	int settings_used = 0;

	eight_neighbor_average_stencil DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.average      (average),
		.out_row      (out_row),
		.out_col      (out_col),
		.frame_last   (frame_last)
	);

	always #5 clk = ~clk;

	function automatic int draw_wait();
		return idle_on ? $urandom_range(0, 15) : 0;
	endfunction

	function automatic logic signed [SB-1:0] draw_sample();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3: return SB'(int'($urandom_range(0, 15)) - 8);
			default: return SB'($urandom());
		endcase
	endfunction

	// check every accepted result word
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(average, out_row, out_col, frame_last);
	end

	// receiver: random stall per word, plus long hold-offs on request
	int rx_stall = 0;
	int rx_hold  = 0;
	always @(posedge clk) begin
		if (result_valid && result_ready)
			rx_stall = draw_wait();
		if (hold_request > 0) begin
			rx_hold      = hold_request;
			hold_request = 0;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			result_ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// offer one sample word after a random gap, hold it until accepted
	task automatic send_sample(logic signed [SB-1:0] value);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= value;
		do @(posedge clk); while (!sample_ready);
		sb.note_sample(value);
	endtask

	// drop valid, wait for every expected word, then let the pipeline empty
	task automatic drain_results(int extra);
		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic apb_write(logic [IDXW-1:0] idx, logic [PDW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read(logic [IDXW-1:0] idx, output logic [PDW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(logic [IDXW-1:0] idx);
		logic [PDW-1:0] got;
		apb_read(idx, got);
		if (got !== sb.reg_value(idx))
			sb.flag($sformatf("register %0d reads %0h, expected %0h",
				idx, got, sb.reg_value(idx)));
	endtask

	// write a register with the block idle, mirror it, read it back
	task automatic write_cfg(logic [IDXW-1:0] idx, logic [PDW-1:0] value);
		drain_results(8);
		apb_write(idx, value);
		sb.write_reg(idx, value);
		settings_used++;
		check_reg(idx);
	endtask

	initial begin
		int n;
		int frame_len;
		int pick;
		sb = new();
		sb.reset_state();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reg(ens_pkg::REG_GRID_WIDTH);
		check_reg(ens_pkg::REG_GRID_HEIGHT);

		// smallest grid, both registers below range
		write_cfg(ens_pkg::REG_GRID_WIDTH, 0);
		write_cfg(ens_pkg::REG_GRID_HEIGHT, 2);
		// full-scale frames, then one frame probing floor and center exclusion;
		// frames follow each other so the counters wrap
		repeat (9) send_sample(S_MAX);
		repeat (9) send_sample(S_MIN);
		for (int i = 0; i < 9; i++)
			send_sample((i == 0) ? SB'(-1) : (i == 4) ? SB'(5) : SB'(0));

		// tallest grid on three columns; hold the output off long enough
		// for the block to back up its input while words keep coming
		write_cfg(ens_pkg::REG_GRID_WIDTH, 1);
		write_cfg(ens_pkg::REG_GRID_HEIGHT, 16'hFFFF);
		idle_on = 1'b0;
		hold_request = 300;
		repeat (60) send_sample(draw_sample());
		idle_on = 1'b1;

		// widest grid: width above range clamps
		write_cfg(ens_pkg::REG_GRID_WIDTH, 11'h7FF);
		write_cfg(ens_pkg::REG_GRID_HEIGHT, 3);
		repeat (40) send_sample(draw_sample());

		// random phases: mostly small grids, occasional large ones
		for (int phase = 0; sb.samples_seen < 1200; phase++) begin
			idle_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 3);
			if (pick == 0) begin
				// pause until the block has emptied, keep the frame going
				drain_results(1);
			end
			if (pick == 1 || pick == 3) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: n = $urandom_range(0, 10);
					7, 8: n = $urandom_range(11, 40);
					default: n = $urandom_range(0, 2047);
				endcase
				write_cfg(ens_pkg::REG_GRID_WIDTH, n);
			end
			if (pick == 2 || pick == 3) begin
				n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(0, 65535);
				write_cfg(ens_pkg::REG_GRID_HEIGHT, n);
			end
			// stall the output for a long stretch now and then
			if (phase == 3 || phase == 20) begin
				idle_on = 1'b0;
				hold_request = 300;
			end
			frame_len = sb.eff_width() * sb.eff_height();
			if (frame_len <= 150 && $urandom_range(0, 1))
				n = frame_len * $urandom_range(1, 2);
			else
				n = $urandom_range(8, 120);
			repeat (n) send_sample(draw_sample());
		end

		drain_results(12);
		$display("covered %0d samples over %0d register writes",
			sb.samples_seen, settings_used);
		$display("checked %0d averages, %0d of them closing a frame",
			sb.points_checked, sb.frames_closed);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#8000000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: sim.f
src/ens_pkg.sv
src/ens_ram.sv
src/eight_neighbor_average_stencil.sv
test/eight_neighbor_average_stencil_tb.sv
